// ----- sv/api_frame_receiver_defines.svh -----
// Assertion macros used by the port-level checker of the frame receiver.
// Depends on a clk and an active-low rst_n in the scope where a macro is used.
`ifndef API_FRAME_RECEIVER_DEFINES_SVH
`define API_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge and off during reset.
`define AFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge and off during reset.
`define AFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/afr_pkg.sv -----
// Types and constants of the frame receiver.
// No dependencies; used by the parser, the top level and the checkers.
package afr_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_API_ID = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TYPE        = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STATUS_TYPE     = 2'd3;

    localparam logic [15:0] TIMEOUT_TICKS_RESET   = 16'd2000;
    localparam logic [7:0]  EXPECTED_API_ID_RESET = 8'h81;
    localparam logic [7:0]  ACK_TYPE_RESET        = 8'h02;
    localparam logic [7:0]  STATUS_TYPE_RESET     = 8'h04;

    localparam logic [7:0]  START_BYTE    = 8'h7E;
    localparam logic [7:0]  CSUM_BASE     = 8'hFF;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MSB  = 3'd1;
    localparam logic [2:0] PH_LSB  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CSUM = 3'd4;

    localparam logic [2:0] OUTCOME_BAD_CSUM = 3'd0;
    localparam logic [2:0] OUTCOME_WRONG_ID = 3'd1;
    localparam logic [2:0] OUTCOME_PAIR_ACK = 3'd2;
    localparam logic [2:0] OUTCOME_STATUS   = 3'd3;
    localparam logic [2:0] OUTCOME_OTHER    = 3'd4;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [7:0]  expected_api_id;
        logic [7:0]  ack_type;
        logic [7:0]  status_type;
    } cfg_t;

    typedef struct packed {
        logic [2:0] outcome;
        logic [7:0] fuel_level;
    } result_t;

endpackage

// ----- sv/afr_if.sv -----
// Valid/ready channel interfaces for received items and frame results.
// No dependencies.
interface afr_item_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface afr_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] outcome;
    logic [7:0] fuel_level;

    modport source (output valid, output outcome, output fuel_level, input ready);
    modport sink (input valid, input outcome, input fuel_level, output ready);
endinterface

// ----- sv/afr_parser.sv -----
// Frame parser state and its one-item update for the frame receiver.
// Depends on afr_pkg.
module afr_parser #(
    parameter int TYPE_POSITION = 5,
    parameter int FUEL_POSITION = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             cmd,
    input  logic [7:0]       rx_byte,
    input  afr_pkg::cfg_t    cfg,
    output logic             emit,
    output afr_pkg::result_t res
);
    import afr_pkg::*;

    localparam logic [15:0] TYPE_INDEX = 16'(TYPE_POSITION);
    localparam logic [15:0] FUEL_INDEX = 16'(FUEL_POSITION);

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [15:0] idle_ticks_reg, idle_ticks_next;
    logic [7:0]  api_byte_reg, api_byte_next;
    logic [7:0]  type_byte_reg, type_byte_next;
    logic [7:0]  pending_fuel_reg, pending_fuel_next;
    logic [7:0]  fuel_latched_reg, fuel_latched_next;

    logic [15:0] tick_count;
    logic [15:0] count_inc;
    logic [15:0] length_full;

    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        byte_count_next   = byte_count_reg;
        running_sum_next  = running_sum_reg;
        idle_ticks_next   = idle_ticks_reg;
        api_byte_next     = api_byte_reg;
        type_byte_next    = type_byte_reg;
        pending_fuel_next = pending_fuel_reg;
        fuel_latched_next = fuel_latched_reg;
        emit              = 1'b0;
        res.outcome       = OUTCOME_BAD_CSUM;

        tick_count  = (idle_ticks_reg == TICKS_MAX) ? idle_ticks_reg : idle_ticks_reg + 16'd1;
        count_inc   = byte_count_reg + 16'd1;
        length_full = {frame_length_reg[15:8], rx_byte};

        if (cmd == CMD_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                idle_ticks_next = tick_count;
                if (tick_count >= cfg.timeout_ticks)
                begin
                    phase_next      = PH_IDLE;
                    idle_ticks_next = 16'd0;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == START_BYTE)
                    begin
                        frame_length_next = 16'd0;
                        byte_count_next   = 16'd0;
                        running_sum_next  = 8'd0;
                        idle_ticks_next   = 16'd0;
                        api_byte_next     = 8'd0;
                        type_byte_next    = 8'd0;
                        pending_fuel_next = 8'd0;
                        phase_next        = PH_MSB;
                    end
                end
                PH_MSB:
                begin
                    idle_ticks_next   = 16'd0;
                    frame_length_next = {rx_byte, 8'h00};
                    phase_next        = PH_LSB;
                end
                PH_LSB:
                begin
                    idle_ticks_next   = 16'd0;
                    frame_length_next = length_full;
                    running_sum_next  = 8'd0;
                    byte_count_next   = 16'd0;
                    phase_next        = (length_full == 16'd0) ? PH_CSUM : PH_DATA;
                end
                PH_DATA:
                begin
                    idle_ticks_next = 16'd0;
                    if (byte_count_reg == 16'd0)
                    begin
                        api_byte_next = rx_byte;
                    end
                    if (byte_count_reg == TYPE_INDEX)
                    begin
                        type_byte_next = rx_byte;
                    end
                    if (byte_count_reg == FUEL_INDEX)
                    begin
                        pending_fuel_next = rx_byte;
                    end
                    running_sum_next = running_sum_reg + rx_byte;
                    byte_count_next  = count_inc;
                    if (count_inc == frame_length_reg)
                    begin
                        phase_next = PH_CSUM;
                    end
                end
                PH_CSUM:
                begin
                    idle_ticks_next = 16'd0;
                    phase_next      = PH_IDLE;
                    emit            = 1'b1;
                    priority if (rx_byte != (CSUM_BASE - running_sum_reg))
                    begin
                        res.outcome = OUTCOME_BAD_CSUM;
                    end
                    else if (api_byte_reg != cfg.expected_api_id)
                    begin
                        res.outcome = OUTCOME_WRONG_ID;
                    end
                    else
                    begin
                        priority if (type_byte_reg == cfg.ack_type)
                        begin
                            res.outcome = OUTCOME_PAIR_ACK;
                        end
                        else if (type_byte_reg == cfg.status_type)
                        begin
                            res.outcome = OUTCOME_STATUS;
                        end
                        else
                        begin
                            res.outcome = OUTCOME_OTHER;
                        end
                        if (type_byte_reg == cfg.status_type)
                        begin
                            fuel_latched_next = pending_fuel_reg;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        res.fuel_level = fuel_latched_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            frame_length_reg <= 16'd0;
            byte_count_reg   <= 16'd0;
            running_sum_reg  <= 8'd0;
            idle_ticks_reg   <= 16'd0;
            api_byte_reg     <= 8'd0;
            type_byte_reg    <= 8'd0;
            pending_fuel_reg <= 8'd0;
            fuel_latched_reg <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            byte_count_reg   <= byte_count_next;
            running_sum_reg  <= running_sum_next;
            idle_ticks_reg   <= idle_ticks_next;
            api_byte_reg     <= api_byte_next;
            type_byte_reg    <= type_byte_next;
            pending_fuel_reg <= pending_fuel_next;
            fuel_latched_reg <= fuel_latched_next;
        end
    end

endmodule

// ----- sv/api_frame_receiver.sv -----
// Receiver for start-delimited, length-prefixed, checksummed frames.
// Depends on afr_pkg, afr_if.sv and afr_parser.
//
// Each transfer on the item channel is one received byte or one timer tick, and the block
// takes one such transfer every clock cycle unless the item channel stalls. A transfer is
// held in an input register, from which the parser updates its frame state, and a checksum
// byte places one result in the output register, from which the result is offered. The
// item channel stalls only while a checksum byte waits in the input register behind a
// result that the result channel has not yet taken.
// Configuration writes are meant for a quiet block and take effect at the next edge.
module api_frame_receiver #(
    parameter int TYPE_POSITION = 5,
    parameter int FUEL_POSITION = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [afr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [afr_pkg::CFG_DATA_W-1:0]     cfg_data,
    afr_item_if.sink                           items,
    afr_result_if.source                       results
);
    import afr_pkg::*;

    cfg_t       cfg_reg;
    logic       item_valid_reg;
    logic       item_cmd_reg;
    logic [7:0] item_byte_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;

    logic       emit;
    result_t    res;
    logic       out_free;
    logic       advance;

    assign out_free    = !out_valid_reg || results.ready;
    assign advance     = item_valid_reg && (!emit || out_free);
    assign items.ready = !item_valid_reg || advance;

    assign results.valid      = out_valid_reg;
    assign results.outcome    = out_data_reg.outcome;
    assign results.fuel_level = out_data_reg.fuel_level;

    afr_parser #(
        .TYPE_POSITION (TYPE_POSITION),
        .FUEL_POSITION (FUEL_POSITION)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cmd     (item_cmd_reg),
        .rx_byte (item_byte_reg),
        .cfg     (cfg_reg),
        .emit    (emit),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks   <= TIMEOUT_TICKS_RESET;
            cfg_reg.expected_api_id <= EXPECTED_API_ID_RESET;
            cfg_reg.ack_type        <= ACK_TYPE_RESET;
            cfg_reg.status_type     <= STATUS_TYPE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT_TICKS:   cfg_reg.timeout_ticks   <= cfg_data;
                CFG_EXPECTED_API_ID: cfg_reg.expected_api_id <= cfg_data[7:0];
                CFG_ACK_TYPE:        cfg_reg.ack_type        <= cfg_data[7:0];
                CFG_STATUS_TYPE:     cfg_reg.status_type     <= cfg_data[7:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            item_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            item_cmd_reg  <= items.cmd;
            item_byte_reg <= items.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && emit)
        begin
            out_data_reg <= res;
        end
    end

endmodule

// ----- sv/afr_checker.sv -----
// Port-level checks of the frame receiver, bound to the top level.
// Depends on afr_pkg and api_frame_receiver_defines.svh.
`include "api_frame_receiver_defines.svh"

module afr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [2:0] outcome,
    input logic [7:0] fuel_level
);
    import afr_pkg::*;

    // With no result waiting, nothing can hold back the item channel.
    `AFR_ASSERT_NOW(a_ready_when_out_empty, !result_valid, item_ready, "item channel stalled with an empty result slot")

    `AFR_ASSERT_NOW(a_outcome_range, result_valid, outcome <= OUTCOME_OTHER, "outcome code out of range")

    `AFR_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(outcome) && $stable(fuel_level), "stalled result changed")

endmodule

bind api_frame_receiver afr_checker u_afr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (items.ready),
    .result_valid (results.valid),
    .result_ready (results.ready),
    .outcome      (results.outcome),
    .fuel_level   (results.fuel_level)
);

// ----- tb/sv/afr_report_checker.sv -----
// Checker for the frame receiver: follows every transfer and register write, predicts
// the report of each completed frame and compares it with the result channel.
// Depends on afr_pkg and the channel interfaces of afr_if.sv.
module afr_report_checker #(
    parameter int TYPE_POSITION = 5,
    parameter int FUEL_POSITION = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [afr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [afr_pkg::CFG_DATA_W-1:0]  cfg_data,
    afr_item_if                             items,
    afr_result_if                           results,
    output int                              mismatch_count,
    output int                              reports_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import afr_pkg::*;

    cfg_t        cfg_q;
    logic [2:0]  phase_q;
    logic [15:0] frame_len;
    logic [15:0] byte_cnt;
    logic [15:0] tick_cnt;
    logic [7:0]  sum_q;
    logic [7:0]  api_q;
    logic [7:0]  type_q;
    logic [7:0]  fuel_pend;
    logic [7:0]  fuel_q;
    result_t     due_reports[$];

    task automatic clear_parser();
        cfg_q.timeout_ticks   = TIMEOUT_TICKS_RESET;
        cfg_q.expected_api_id = EXPECTED_API_ID_RESET;
        cfg_q.ack_type        = ACK_TYPE_RESET;
        cfg_q.status_type     = STATUS_TYPE_RESET;
        phase_q   = PH_IDLE;
        frame_len = '0;
        byte_cnt  = '0;
        tick_cnt  = '0;
        sum_q     = '0;
        api_q     = '0;
        type_q    = '0;
        fuel_pend = '0;
        fuel_q    = '0;
        due_reports.delete();
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        case (idx)
            CFG_TIMEOUT_TICKS:   cfg_q.timeout_ticks   = data;
            CFG_EXPECTED_API_ID: cfg_q.expected_api_id = data[7:0];
            CFG_ACK_TYPE:        cfg_q.ack_type        = data[7:0];
            CFG_STATUS_TYPE:     cfg_q.status_type     = data[7:0];
            default: ;
        endcase
    endtask

    task automatic parse_item(input logic cmd, input logic [7:0] b);
        result_t    rep;
        logic [7:0] want_csum;
        if (cmd == CMD_TICK) begin
            if (phase_q != PH_IDLE) begin
                if (tick_cnt != TICKS_MAX)
                    tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= cfg_q.timeout_ticks) begin
                    phase_q  = PH_IDLE;
                    tick_cnt = '0;
                end
            end
        end
        else begin
            case (phase_q)
                PH_IDLE:
                begin
                    if (b == START_BYTE) begin
                        frame_len = '0;
                        byte_cnt  = '0;
                        sum_q     = '0;
                        tick_cnt  = '0;
                        api_q     = '0;
                        type_q    = '0;
                        fuel_pend = '0;
                        phase_q   = PH_MSB;
                    end
                end
                PH_MSB:
                begin
                    tick_cnt  = '0;
                    frame_len = {b, 8'h00};
                    phase_q   = PH_LSB;
                end
                PH_LSB:
                begin
                    tick_cnt  = '0;
                    frame_len = {frame_len[15:8], b};
                    sum_q     = '0;
                    byte_cnt  = '0;
                    phase_q   = (frame_len == 16'd0) ? PH_CSUM : PH_DATA;
                end
                PH_DATA:
                begin
                    tick_cnt = '0;
                    if (byte_cnt == 16'd0)
                        api_q = b;
                    if (byte_cnt == 16'(TYPE_POSITION))
                        type_q = b;
                    if (byte_cnt == 16'(FUEL_POSITION))
                        fuel_pend = b;
                    sum_q    = sum_q + b;
                    byte_cnt = byte_cnt + 16'd1;
                    if (byte_cnt == frame_len)
                        phase_q = PH_CSUM;
                end
                PH_CSUM:
                begin
                    tick_cnt  = '0;
                    phase_q   = PH_IDLE;
                    want_csum = CSUM_BASE - sum_q;
                    if (b != want_csum)
                        rep.outcome = OUTCOME_BAD_CSUM;
                    else if (api_q != cfg_q.expected_api_id)
                        rep.outcome = OUTCOME_WRONG_ID;
                    else begin
                        if (type_q == cfg_q.ack_type)
                            rep.outcome = OUTCOME_PAIR_ACK;
                        else if (type_q == cfg_q.status_type)
                            rep.outcome = OUTCOME_STATUS;
                        else
                            rep.outcome = OUTCOME_OTHER;
                        if (type_q == cfg_q.status_type)
                            fuel_q = fuel_pend;
                    end
                    rep.fuel_level = fuel_q;
                    due_reports.push_back(rep);
                end
                default: phase_q = PH_IDLE;
            endcase
        end
    endtask

    task automatic compare_report();
        result_t want;
        if (due_reports.size() == 0) begin
            $error("result with no frame report due: outcome %0d, fuel_level %0d",
                   results.outcome, results.fuel_level);
            mismatch_count++;
        end
        else begin
            want = due_reports.pop_front();
            if (results.outcome !== want.outcome) begin
                $error("outcome: expected %0d, actual %0d", want.outcome, results.outcome);
                mismatch_count++;
            end
            if (results.fuel_level !== want.fuel_level) begin
                $error("fuel_level: expected %0d, actual %0d",
                       want.fuel_level, results.fuel_level);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_parser();
            mismatch_count = 0;
            reports_due    = 0;
        end
        else begin
            if (results.valid && results.ready)
                compare_report();
            if (cfg_we)
                write_cfg(cfg_index, cfg_data);
            if (items.valid && items.ready)
                parse_item(items.cmd, items.rx_byte);
            reports_due = due_reports.size();
        end
    end

endmodule

// ----- tb/sv/tb_api_frame_receiver.sv -----
// Top of the frame receiver testbench: clock, reset, register writes, item and result
// traffic, watchdog and verdict. Depends on afr_pkg, afr_if.sv, the receiver RTL and
// afr_report_checker.
module tb_api_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;
    import afr_pkg::*;

    localparam int TYPE_POSITION  = 5;
    localparam int FUEL_POSITION  = 6;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int   mismatch_count;
    int   reports_due;
    int   items_sent = 0;
    int   idle_cycles = 0;
    int   src_odds = 0;
    int   snk_odds = 0;
    bit   hold_req = 1'b0;

    int          cur_timeout = TIMEOUT_TICKS_RESET;
    logic [7:0]  cur_api     = EXPECTED_API_ID_RESET;
    logic [7:0]  cur_ack     = ACK_TYPE_RESET;
    logic [7:0]  cur_status  = STATUS_TYPE_RESET;

    afr_item_if   item_ch();
    afr_result_if result_ch();

    api_frame_receiver #(
        .TYPE_POSITION(TYPE_POSITION),
        .FUEL_POSITION(FUEL_POSITION)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .items(item_ch),
        .results(result_ch)
    );

    afr_report_checker #(
        .TYPE_POSITION(TYPE_POSITION),
        .FUEL_POSITION(FUEL_POSITION)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .items(item_ch),
        .results(result_ch),
        .mismatch_count(mismatch_count),
        .reports_due(reports_due)
    );

    always #6ns clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no transfer in %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // The result side stalls in random bursts, and once holds off for a long stretch
    // so that the receiver fills up and stalls its item channel.
    initial begin : result_sink
        int n;
        result_ch.ready = 1'b1;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (snk_odds != 0 && $urandom_range(0, snk_odds - 1) == 0) begin
                n = $urandom_range(1, 19);
                result_ch.ready <= 1'b0;
                repeat (n) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic put_item(input logic cmd, input logic [7:0] b);
        int n;
        if (src_odds != 0 && $urandom_range(0, src_odds - 1) == 0) begin
            n = $urandom_range(1, 19);
            @(negedge clk);
            item_ch.valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        item_ch.valid   <= 1'b1;
        item_ch.cmd     <= cmd;
        item_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
    endtask

    task automatic send_frame(input logic [15:0] len, input logic [7:0] api,
                              input logic [7:0] typ, input logic [7:0] fuel,
                              input bit good, input int tick_odds);
        logic [7:0] sum;
        logic [7:0] b;
        int         i;
        sum = '0;
        put_item(CMD_BYTE, START_BYTE);
        put_item(CMD_BYTE, len[15:8]);
        put_item(CMD_BYTE, len[7:0]);
        for (i = 0; i < int'(len); i++) begin
            if (i == 0)
                b = api;
            else if (i == TYPE_POSITION)
                b = typ;
            else if (i == FUEL_POSITION)
                b = fuel;
            else
                b = ($urandom_range(0, 15) == 0) ? START_BYTE : 8'($urandom);
            if (tick_odds != 0 && $urandom_range(0, tick_odds - 1) == 0)
                put_item(CMD_TICK, 8'($urandom));
            put_item(CMD_BYTE, b);
            sum = sum + b;
        end
        b = CSUM_BASE - sum;
        if (!good)
            b = b ^ 8'($urandom_range(1, 255));
        put_item(CMD_BYTE, b);
    endtask

    // Waits until every predicted report has been taken and the pipeline has drained.
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (reports_due != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input int t, input logic [7:0] a, input logic [7:0] k,
                              input logic [7:0] s);
        settle();
        write_reg(CFG_TIMEOUT_TICKS, t[15:0]);
        write_reg(CFG_EXPECTED_API_ID, {8'($urandom), a});
        write_reg(CFG_ACK_TYPE, {8'($urandom), k});
        write_reg(CFG_STATUS_TYPE, {8'($urandom), s});
        cur_timeout = t;
        cur_api     = a;
        cur_ack     = k;
        cur_status  = s;
    endtask

    task automatic run_random(input int budget, input bit stalls);
        int          goal;
        int          sel;
        int          n;
        int          base;
        logic [15:0] len;
        logic [7:0]  api;
        logic [7:0]  typ;
        goal = items_sent + budget;
        while (items_sent < goal) begin
            if (stalls && $urandom_range(0, 19) == 0) begin
                src_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
                snk_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
            end
            sel = $urandom_range(0, 99);
            len = ($urandom_range(0, 79) == 0) ? 16'($urandom_range(11, 300))
                                               : 16'($urandom_range(0, 10));
            api = ($urandom_range(0, 3) == 0) ? 8'($urandom) : cur_api;
            case ($urandom_range(0, 3))
                0:       typ = cur_ack;
                1:       typ = cur_status;
                default: typ = 8'($urandom);
            endcase
            if (sel < 75) begin
                send_frame(len, api, typ, 8'($urandom), $urandom_range(0, 7) != 0,
                           ($urandom_range(0, 3) == 0) ? 4 : 0);
            end
            else if (sel < 88) begin
                // A header with a payload cut short, then, for a timeout of at most 20 ticks, ticks up to the timeout.
                len = (cur_timeout <= 20) ? 16'($urandom) : 16'($urandom_range(1, 10));
                put_item(CMD_BYTE, START_BYTE);
                put_item(CMD_BYTE, len[15:8]);
                put_item(CMD_BYTE, len[7:0]);
                repeat ($urandom_range(0, 3)) put_item(CMD_BYTE, 8'($urandom));
                if (cur_timeout <= 20)
                    repeat (cur_timeout) put_item(CMD_TICK, 8'($urandom));
            end
            else begin
                base = items_sent;
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 1) == 0)
                        put_item(CMD_TICK, 8'($urandom));
                    else
                        put_item(CMD_BYTE, 8'($urandom));
                end
                items_sent = base;
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] v;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.cmd     = CMD_BYTE;
        item_ch.rx_byte = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        put_item(CMD_TICK, 8'hFF);
        put_item(CMD_BYTE, 8'h00);
        send_frame(16'd0, 8'h00, 8'h00, 8'h00, 1'b1, 0);
        send_frame(16'd7, EXPECTED_API_ID_RESET, STATUS_TYPE_RESET, 8'hFF, 1'b1, 0);
        send_frame(16'd1, EXPECTED_API_ID_RESET, 8'h00, 8'h00, 1'b0, 1);

        src_odds = 4;
        snk_odds = 4;
        run_random(200, 1'b1);

        set_config(1, 8'h00, 8'hFF, 8'h00);
        src_odds = 0;
        hold_req = 1'b1;
        repeat (12) send_frame(16'd0, 8'h00, 8'h00, 8'h00, 1'b1, 0);
        run_random(250, 1'b1);

        set_config(65535, 8'hFF, 8'h00, 8'hFF);
        run_random(250, 1'b1);

        v = 8'($urandom);
        set_config($urandom_range(2, 12), 8'($urandom), v, v);
        run_random(250, 1'b1);

        set_config($urandom_range(13, 2000), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random(250, 1'b1);

        set_config(TIMEOUT_TICKS_RESET, EXPECTED_API_ID_RESET, ACK_TYPE_RESET,
                   STATUS_TYPE_RESET);
        src_odds = 0;
        snk_odds = 0;
        run_random(200, 1'b0);

        settle();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
